>>> rtl/base64_stream_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Base64 decoder assertion macros
// Concurrent assertion shorthands on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// property must hold at every clock edge out of reset
`define B64D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen out of reset
`define B64D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared constants, queue entry type, status codes and symbol lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int MaxChars = 4096;
  localparam int ScW      = $clog2(MaxChars + 1);
  localparam int LenW     = 12;
  localparam int CapW     = 12;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam logic [6:0] NotSym = 7'd127;
  localparam logic [6:0] PadSym = 7'd64;

  localparam logic [LenW-1:0] LenMax = '1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StSmall   = 2'd2,
    StLong    = 2'd3
  } status_e;

  typedef struct packed {
    logic [23:0]     bits;
    logic [1:0]      nbytes;
    logic            fin;
    status_e         err;
    logic [ScW-1:0]  sc;
    logic [1:0]      pads;
    logic [LenW-1:0] emitted;
  } q_entry_t;

  function automatic logic [6:0] sym_lookup(input logic [7:0] c);
    logic [6:0] v;
    v = NotSym;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == 8'h3D) begin
      v = PadSym;
    end
    return v;
  endfunction

endpackage

>>> rtl/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// One character per request in; decoded bytes and a closing status out.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle as long as its four-entry request
// queue has room. Each completed quartet yields one to three data bytes, and
// the character marked last yields one status result (ok with byte count,
// invalid character, buffer too small with required length, or input too
// long). Results leave one per cycle from a registered output stage while the
// consumer is ready, and the input stalls only when the consumer or the
// serializer falls four requests behind. Bytes sent before an error status
// are to be discarded by the consumer. The user is to write out_capacity
// through cfg_we_i and cfg_wdata_i while idle; the block does not enforce it.
module base64_stream_decoder_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [b64d_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                char_code_i,
  input  logic                      last_char_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                data_byte_o,
  output logic                      is_status_o,
  output logic [1:0]                status_o,
  output logic [b64d_pkg::LenW-1:0] length_o,
  output logic                      last_o
);
  import b64d_pkg::*;

  logic     q_push, q_pop, q_empty, q_full;
  q_entry_t q_in, q_head;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .is_status_o (is_status_o),
    .status_o    (status_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, validates them, packs quartets and queues requests.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64d_pkg::q_entry_t q_entry_o
);
  import b64d_pkg::*;

  logic            sp_q, sp_d;
  logic            cr_q, cr_d;
  logic [1:0]      pad_q, pad_d;
  logic [ScW-1:0]  sc_q, sc_d;
  logic [1:0]      gpos_q, gpos_d;
  logic [23:0]     gbits_q, gbits_d;
  logic [LenW-1:0] be_q, be_d;
  status_e         err_q, err_d;

  logic       accept;
  logic [6:0] sym;
  logic       take;
  logic [1:0] nb;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sym        = char_code_i[7] ? NotSym : sym_lookup(char_code_i);

  always_comb begin
    sp_d    = sp_q;
    cr_d    = cr_q;
    pad_d   = pad_q;
    sc_d    = sc_q;
    gpos_d  = gpos_q;
    gbits_d = gbits_q;
    be_d    = be_q;
    err_d   = err_q;
    take    = 1'b0;
    nb      = 2'd0;
    if (err_q != StInvalid) begin
      if (cr_q) begin
        cr_d = 1'b0;
        if (char_code_i == ChLf) begin
          sp_d = 1'b0;
        end else begin
          err_d = StInvalid;
        end
      end else if (char_code_i == ChSpace) begin
        sp_d = 1'b1;
      end else if (char_code_i == ChCr) begin
        cr_d = 1'b1;
      end else if (char_code_i == ChLf) begin
        sp_d = 1'b0;
      end else if (sp_q || sym == NotSym) begin
        err_d = StInvalid;
      end else if (sym == PadSym) begin
        if (pad_q >= 2'd2) begin
          err_d = StInvalid;
        end else begin
          pad_d = pad_q + 2'd1;
          take  = 1'b1;
        end
      end else if (pad_q != 2'd0) begin
        err_d = StInvalid;
      end else begin
        take = 1'b1;
      end
      if (take) begin
        if (sc_q >= ScW'(MaxChars)) begin
          if (err_q == StOk) begin
            err_d = StLong;
          end
        end else begin
          sc_d = sc_q + ScW'(1);
          if (err_q == StOk) begin
            gbits_d = {gbits_q[17:0], sym[5:0]};
            gpos_d  = gpos_q + 2'd1;
            if (gpos_d == 2'd0) begin
              nb   = 2'd3 - pad_d;
              be_d = be_q + LenW'(nb);
            end
          end
        end
      end
    end
    if (last_char_i && cr_d) begin
      err_d = StInvalid;
    end
  end

  always_comb begin
    q_push_o          = accept && (nb != 2'd0 || last_char_i);
    q_entry_o.bits    = gbits_d;
    q_entry_o.nbytes  = nb;
    q_entry_o.fin     = last_char_i;
    q_entry_o.err     = err_d;
    q_entry_o.sc      = sc_d;
    q_entry_o.pads    = pad_d;
    q_entry_o.emitted = be_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= 1'b0;
      cr_q    <= 1'b0;
      pad_q   <= 2'd0;
      sc_q    <= '0;
      gpos_q  <= 2'd0;
      gbits_q <= '0;
      be_q    <= '0;
      err_q   <= StOk;
    end else if (accept) begin
      if (last_char_i) begin
        sp_q    <= 1'b0;
        cr_q    <= 1'b0;
        pad_q   <= 2'd0;
        sc_q    <= '0;
        gpos_q  <= 2'd0;
        gbits_q <= '0;
        be_q    <= '0;
        err_q   <= StOk;
      end else begin
        sp_q    <= sp_d;
        cr_q    <= cr_d;
        pad_q   <= pad_d;
        sc_q    <= sc_d;
        gpos_q  <= gpos_d;
        gbits_q <= gbits_d;
        be_q    <= be_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// Base64 decoder request queue
// Small FIFO between the front end and the output serializer.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64d_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output b64d_pkg::q_entry_t head_o,
  output logic               empty_o,
  output logic               full_o
);
  import b64d_pkg::*;

  q_entry_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Serializes queued requests into data bytes and the closing status.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [b64d_pkg::CapW-1:0] cfg_wdata_i,
  input  b64d_pkg::q_entry_t        head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                data_byte_o,
  output logic                      is_status_o,
  output logic [1:0]                status_o,
  output logic [b64d_pkg::LenW-1:0] length_o,
  output logic                      last_o
);
  import b64d_pkg::*;

  localparam int NeedW = ScW + 3;

  logic [CapW-1:0]  cap_q;
  logic [1:0]       idx_q, idx_d;
  logic             vld_q, vld_d;
  logic [7:0]       byte_q, byte_d;
  logic             ist_q, ist_d;
  status_e          st_q, st_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             lst_q, lst_d;

  logic             load;
  logic [NeedW-1:0] prod;
  logic [NeedW-1:0] need;
  logic [LenW-1:0]  need_sat;
  logic             too_small;

  assign prod      = {head_i.sc, 2'b00} + {1'b0, head_i.sc, 1'b0} + NeedW'(7);
  assign need      = (prod >> 3) - NeedW'(head_i.pads);
  assign need_sat  = (need > NeedW'(LenMax)) ? LenMax : need[LenW-1:0];
  assign too_small = NeedW'(cap_q) < need;
  assign load      = !vld_q || out_ready_i;

  always_comb begin
    pop_o  = 1'b0;
    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    byte_d = byte_q;
    ist_d  = ist_q;
    st_d   = st_q;
    len_d  = len_q;
    lst_d  = lst_q;
    if (load && !empty_i) begin
      vld_d = 1'b1;
      if (idx_q < head_i.nbytes) begin
        case (idx_q)
          2'd0:    byte_d = head_i.bits[23:16];
          2'd1:    byte_d = head_i.bits[15:8];
          default: byte_d = head_i.bits[7:0];
        endcase
        ist_d = 1'b0;
        st_d  = StOk;
        len_d = '0;
        lst_d = 1'b0;
        if (idx_q == head_i.nbytes - 2'd1 && !head_i.fin) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end else begin
        byte_d = 8'd0;
        ist_d  = 1'b1;
        lst_d  = 1'b1;
        pop_o  = 1'b1;
        idx_d  = 2'd0;
        if (head_i.err != StOk) begin
          st_d  = head_i.err;
          len_d = '0;
        end else if (head_i.sc == '0) begin
          st_d  = StOk;
          len_d = '0;
        end else if (too_small) begin
          st_d  = StSmall;
          len_d = need_sat;
        end else begin
          st_d  = StOk;
          len_d = head_i.emitted;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(3072);
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    ist_q  <= ist_d;
    st_q   <= st_d;
    len_q  <= len_d;
    lst_q  <= lst_d;
  end

  assign out_valid_o = vld_q;
  assign data_byte_o = byte_q;
  assign is_status_o = ist_q;
  assign status_o    = st_q;
  assign length_o    = len_q;
  assign last_o      = lst_q;

endmodule

>>> rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// Base64 decoder port checker
// Watches the top-level ports for result encoding and output hold rules.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_unit_assert.svh"

module b64d_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [b64d_pkg::CapW-1:0] cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [7:0]                char_code_i,
  input logic                      last_char_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [7:0]                data_byte_o,
  input logic                      is_status_o,
  input logic [1:0]                status_o,
  input logic [b64d_pkg::LenW-1:0] length_o,
  input logic                      last_o
);
  import b64d_pkg::*;

  logic unused_in;
  assign unused_in = ^{cfg_we_i, cfg_wdata_i, in_valid_i, in_ready_o,
                       char_code_i, last_char_i};

  `B64D_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) && $stable(is_status_o) && $stable(length_o) && $stable(last_o))
  `B64D_ASSERT_NEVER(a_last_is_status, out_valid_o && (last_o != is_status_o))
  `B64D_ASSERT(a_data_clean, out_valid_o && !is_status_o |-> status_o == StOk && length_o == '0)
  `B64D_ASSERT(a_err_len_zero, out_valid_o && is_status_o && (status_o == StInvalid || status_o == StLong) |-> length_o == '0)

endmodule

bind base64_stream_decoder_unit b64d_checker u_chk (.*);
